// ----- hw/rtl/rsdz_pkg.sv -----
// Shared constants for the radial stick dead zone block.
package rsdz_pkg;

    localparam int RADIUS_BITS    = 15;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 15;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_ZONE_RADIUS = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_ZONE_ENABLE = 1'd1;

endpackage

// ----- hw/rtl/rsdz_if.sv -----
// Sample and result channel interfaces for the radial stick dead zone block.
interface rsdz_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] axis_x;
    logic signed [SAMPLE_BITS-1:0] axis_y;

    modport source (output valid, axis_x, axis_y, input ready);
    modport sink   (input valid, axis_x, axis_y, output ready);
endinterface

interface rsdz_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_x;
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic                          in_dead_zone;

    modport source (output valid, out_x, out_y, in_dead_zone, input ready);
    modport sink   (input valid, out_x, out_y, in_dead_zone, output ready);
endinterface

// ----- hw/rtl/rsdz_divider.sv -----
// Pipelined restoring divider giving a saturated fractional quotient.
module rsdz_divider #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [2*SAMPLE_BITS-1:0]    num,
    input  logic [2*SAMPLE_BITS-1:0]    den,
    output logic [SAMPLE_BITS-2:0]      quot
);
    localparam int F  = SAMPLE_BITS - 1;
    localparam int DW = 2 * SAMPLE_BITS;

    logic [DW-1:0] rem_reg [0:F];
    logic [DW-1:0] den_reg [0:F];
    logic [F-1:0]  q_reg   [0:F];
    logic          sat_reg [0:F];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (num >= den);
        end
    end

    for (genvar i = 0; i < F; i++)
    begin : g_iter
        logic [DW:0] sh;
        logic [DW:0] diff;
        logic        take;

        always_comb
        begin
            sh   = {rem_reg[i], 1'b0};
            diff = sh - {1'b0, den_reg[i]};
            take = (sh >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1] <= take ? diff[DW-1:0] : sh[DW-1:0];
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= {q_reg[i][F-2:0], take};
                sat_reg[i+1] <= sat_reg[i];
            end
        end
    end

    assign quot = sat_reg[F] ? {F{1'b1}} : q_reg[F];

endmodule

// ----- hw/rtl/radial_stick_dead_zone.sv -----
// Scaled radial dead zone for one analog stick sample, top level.
// Takes one sample per cycle unless the result side stalls, and returns one result per
// sample, in order. Stages: squares, one integer square root stage per result bit, the
// rescale products, then one divider stage per fraction bit for both axes. A stall at
// the result side holds the whole pipe. The user must write radius and enable through
// the cfg port only while no transaction is in flight; the block does not enforce it.
module radial_stick_dead_zone #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rsdz_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rsdz_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    rsdz_in_if.sink                             sample,
    rsdz_out_if.source                          result
);
    import rsdz_pkg::*;

    localparam int S   = SAMPLE_BITS;
    localparam int F   = S - 1;
    localparam int M2W = 2 * S;
    localparam int L   = 2 * S + 5;

    typedef struct packed {
        logic [S-1:0] x;
        logic [S-1:0] y;
        logic [S-1:0] ax;
        logic [S-1:0] ay;
        logic         indz;
        logic         zero;
    } side_t;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic                   enable_reg;
    logic [L-1:0]           vld_reg;
    logic                   adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEAD_ZONE_RADIUS: radius_reg <= cfg_wdata[RADIUS_BITS-1:0];
                REG_DEAD_ZONE_ENABLE: enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // radius rescaled to the sample fraction width
    logic [RADIUS_BITS+F-1:0] rad_ext;
    logic [F-1:0]             dz;
    assign rad_ext = {radius_reg, {F{1'b0}}};
    assign dz      = rad_ext[RADIUS_BITS +: F];

    assign adv          = !vld_reg[L-1] || result.ready;
    assign sample.ready = adv;
    assign result.valid = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[L-2:0], sample.valid};
    end

    // stage 1: capture
    logic [S-1:0] x1_reg, y1_reg;
    logic [S-1:0] ax1, ay1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= sample.axis_x;
            y1_reg <= sample.axis_y;
        end
    end

    assign ax1 = x1_reg[S-1] ? (~x1_reg + 1'b1) : x1_reg;
    assign ay1 = y1_reg[S-1] ? (~y1_reg + 1'b1) : y1_reg;

    // stage 2: squares
    logic [S-1:0]   x2_reg, y2_reg, ax2_reg, ay2_reg;
    logic [M2W-1:0] sqx2_reg, sqy2_reg;
    logic [2*F-1:0] dzsq2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            ax2_reg   <= ax1;
            ay2_reg   <= ay1;
            sqx2_reg  <= ax1 * ax1;
            sqy2_reg  <= ay1 * ay1;
            dzsq2_reg <= dz * dz;
        end
    end

    // stage 3: squared magnitude and region flags
    logic [M2W-1:0] mag2;
    logic [M2W-1:0] sq_v_reg   [0:S];
    logic [M2W-1:0] sq_res_reg [0:S];
    side_t          side_sq_reg [0:S];

    assign mag2 = sqx2_reg + sqy2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0]         <= mag2;
            sq_res_reg[0]       <= '0;
            side_sq_reg[0].x    <= x2_reg;
            side_sq_reg[0].y    <= y2_reg;
            side_sq_reg[0].ax   <= ax2_reg;
            side_sq_reg[0].ay   <= ay2_reg;
            side_sq_reg[0].indz <= (mag2 < M2W'(dzsq2_reg));
            side_sq_reg[0].zero <= (mag2 == '0);
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < S; k++)
    begin : g_sqrt
        localparam logic [M2W-1:0] BIT = M2W'(1) << (2 * S - 2 - 2 * k);
        logic [M2W-1:0] trial;
        logic           take;

        always_comb
        begin
            trial = sq_res_reg[k] + BIT;
            take  = (sq_v_reg[k] >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_v_reg[k+1]    <= take ? (sq_v_reg[k] - trial) : sq_v_reg[k];
                sq_res_reg[k+1]  <= take ? ((sq_res_reg[k] >> 1) + BIT)
                                         : (sq_res_reg[k] >> 1);
                side_sq_reg[k+1] <= side_sq_reg[k];
            end
        end
    end

    // rescale products
    logic [S-1:0]   mag;
    logic [S-1:0]   mag_sub;
    logic [S-1:0]   unit_sub;
    logic [M2W-1:0] prod_x_reg, prod_y_reg, den_reg;
    side_t          side_p_reg;

    assign mag      = sq_res_reg[S][S-1:0];
    assign mag_sub  = mag - {1'b0, dz};
    assign unit_sub = {1'b1, {F{1'b0}}} - {1'b0, dz};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg <= side_sq_reg[S].ax * mag_sub;
            prod_y_reg <= side_sq_reg[S].ay * mag_sub;
            den_reg    <= mag * unit_sub;
            side_p_reg <= side_sq_reg[S];
        end
    end

    // per-axis divide
    logic [F-1:0] qx, qy;
    side_t        side_dv_reg [0:F];

    rsdz_divider #(.SAMPLE_BITS(S)) u_div_x (
        .clk  (clk),
        .adv  (adv),
        .num  (prod_x_reg),
        .den  (den_reg),
        .quot (qx)
    );

    rsdz_divider #(.SAMPLE_BITS(S)) u_div_y (
        .clk  (clk),
        .adv  (adv),
        .num  (prod_y_reg),
        .den  (den_reg),
        .quot (qy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
            side_dv_reg[0] <= side_p_reg;
    end

    for (genvar j = 0; j < F; j++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
                side_dv_reg[j+1] <= side_dv_reg[j];
        end
    end

    // output register
    side_t        sd;
    logic [S-1:0] qx_s, qy_s;
    logic [S-1:0] out_x_next, out_y_next;
    logic         indz_next;
    logic [S-1:0] out_x_reg, out_y_reg;
    logic         indz_reg;

    assign sd   = side_dv_reg[F];
    assign qx_s = sd.x[S-1] ? (~{1'b0, qx} + 1'b1) : {1'b0, qx};
    assign qy_s = sd.y[S-1] ? (~{1'b0, qy} + 1'b1) : {1'b0, qy};

    always_comb
    begin
        indz_next = 1'b0;
        if (!enable_reg)
        begin
            out_x_next = sd.x;
            out_y_next = sd.y;
        end
        else if (sd.indz || sd.zero)
        begin
            out_x_next = '0;
            out_y_next = '0;
            indz_next  = sd.indz;
        end
        else
        begin
            out_x_next = qx_s;
            out_y_next = qy_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            indz_reg  <= indz_next;
        end
    end

    assign result.out_x        = out_x_reg;
    assign result.out_y        = out_y_reg;
    assign result.in_dead_zone = indz_reg;

endmodule

// ----- verif/radial_stick_dead_zone_chk.sv -----
`timescale 1ns / 100ps
// Checker: predicts dead-zone results from accepted samples and compares them in order.
module radial_stick_dead_zone_chk #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rsdz_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rsdz_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    rsdz_in_if.sink                             sample,
    rsdz_out_if.sink                            result,
    output int                                  fail_count,
    output int                                  pending
);
    import rsdz_pkg::*;

    localparam int FRAC = SAMPLE_BITS - 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] y;
        logic                          dz_flag;
    } stick_out_t;

    logic [RADIUS_BITS-1:0] radius_q;
    logic                   enable_q;
    stick_out_t             expected_q[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rescale_axis(logic signed [SAMPLE_BITS-1:0] a,
                                                            logic [63:0] mag,
                                                            logic [63:0] dz);
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0]  mag_a;
        mag_a = (a < 0) ? 64'(-65'(a)) : 64'(a);
        num   = (128'(mag_a) * 128'(mag - dz)) << FRAC;
        q     = num / (128'(mag) * 128'((64'd1 << FRAC) - dz));
        if (q > 128'((64'd1 << FRAC) - 1))
            q = 128'((64'd1 << FRAC) - 1);
        return (a < 0) ? SAMPLE_BITS'(-q) : SAMPLE_BITS'(q);
    endfunction

    function automatic stick_out_t predict_dead_zone(logic signed [SAMPLE_BITS-1:0] x,
                                                     logic signed [SAMPLE_BITS-1:0] y);
        stick_out_t  r;
        logic [63:0] dz;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] mag2;
        logic [63:0] mag;
        r = '0;
        if (!enable_q)
        begin
            r.x = x;
            r.y = y;
            return r;
        end
        dz   = (FRAC >= 15) ? (64'(radius_q) << (FRAC - 15)) : (64'(radius_q) >> (15 - FRAC));
        ax   = (x < 0) ? 64'(-65'(x)) : 64'(x);
        ay   = (y < 0) ? 64'(-65'(y)) : 64'(y);
        mag2 = ax * ax + ay * ay;
        if (mag2 < dz * dz)
            r.dz_flag = 1'b1;
        else if (mag2 != 0)
        begin
            mag = int_sqrt(mag2);
            r.x = rescale_axis(x, mag, dz);
            r.y = rescale_axis(y, mag, dz);
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        stick_out_t e;
        if (!rst_n)
        begin
            radius_q   <= '0;
            enable_q   <= 1'b0;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_DEAD_ZONE_RADIUS)
                    radius_q <= cfg_wdata[RADIUS_BITS-1:0];
                else if (cfg_index == REG_DEAD_ZONE_ENABLE)
                    enable_q <= cfg_wdata[0];
            end
            if (sample.valid && sample.ready)
                expected_q.push_back(predict_dead_zone(sample.axis_x, sample.axis_y));
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction x=%0d y=%0d dz=%0b", $time,
                             result.out_x, result.out_y, result.in_dead_zone);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.x !== result.out_x || e.y !== result.out_y
                        || e.dz_flag !== result.in_dead_zone)
                    begin
                        $display("%0t: expected x=%0d y=%0d dz=%0b actual x=%0d y=%0d dz=%0b",
                                 $time, e.x, e.y, e.dz_flag,
                                 result.out_x, result.out_y, result.in_dead_zone);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/radial_stick_dead_zone_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives samples and register writes into the dead-zone block.
module radial_stick_dead_zone_tb;
    import rsdz_pkg::*;

    localparam int SB = 16;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;
    int                        fail_count;
    int                        pending;
    bit                        steady;

    rsdz_in_if  #(.SAMPLE_BITS(SB)) sample_ch ();
    rsdz_out_if #(.SAMPLE_BITS(SB)) result_ch ();

    radial_stick_dead_zone #(.SAMPLE_BITS(SB)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .sample(sample_ch.sink), .result(result_ch.source)
    );

    radial_stick_dead_zone_chk #(.SAMPLE_BITS(SB)) checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .sample(sample_ch.sink), .result(result_ch.sink),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
        result_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 16);

    // valid stays high after acceptance; drain_pipe drops it, and the next call may for random gaps
    task automatic send_sample(logic signed [SB-1:0] x, logic signed [SB-1:0] y);
        while (!steady && $urandom_range(99) < 16)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.axis_x <= x;
        sample_ch.axis_y <= y;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_pipe();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_mode(logic [CFG_DATA_BITS-1:0] radius, logic en);
        drain_pipe();
        write_reg(REG_DEAD_ZONE_RADIUS, radius);
        write_reg(REG_DEAD_ZONE_ENABLE, {14'd0, en});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_set();
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000);
        send_sample(-16'sh8000, 16'sh0000);
        send_sample(16'sh0000, 16'sh7FFF);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0001, -16'sh0001);
        send_sample(16'sh1000, 16'sh0100);
        send_sample(-16'sh3000, 16'sh2000);
    endtask

    task automatic random_batch(int n);
        int kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(3);
            if (kind == 0)
                send_sample(SB'($urandom_range(400)) - 16'sd200,
                            SB'($urandom_range(400)) - 16'sd200);
            else if (kind == 1)
                send_sample(SB'($urandom_range(8000)) - 16'sd4000,
                            SB'($urandom_range(8000)) - 16'sd4000);
            else
                send_sample(SB'($urandom), SB'($urandom));
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        steady           = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.axis_x = '0;
        sample_ch.axis_y = '0;
        result_ch.ready  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();
        set_mode(15'd0, 1'b1);
        directed_set();
        set_mode(15'h7FFF, 1'b1);
        directed_set();
        set_mode(15'd4096, 1'b1);
        directed_set();

        random_batch(150);
        set_mode(15'd1000, 1'b1);
        random_batch(150);
        steady = 1'b1;
        set_mode(15'd8000, 1'b1);
        random_batch(150);
        steady = 1'b0;
        set_mode(15'h7FFF, 1'b1);
        random_batch(100);
        set_mode(15'd0, 1'b1);
        random_batch(150);
        set_mode(15'h5555, 1'b0);
        random_batch(100);
        for (int k = 0; k < 6; k++)
        begin
            set_mode(CFG_DATA_BITS'($urandom), 1'b1);
            random_batch(40);
        end

        drain_pipe();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/rsdz_pkg.sv
hw/rtl/rsdz_if.sv
hw/rtl/rsdz_divider.sv
hw/rtl/radial_stick_dead_zone.sv
verif/radial_stick_dead_zone_chk.sv
verif/radial_stick_dead_zone_tb.sv
